### rtl/core/srse_pkg.sv
`default_nettype none

package srse_pkg;

  // Geometry of the register file and address space
  localparam int unsigned NumGpr     = 8;
  localparam int unsigned GprIdxW    = $clog2(NumGpr);
  localparam int unsigned WordW      = 16;
  localparam int unsigned ByteW      = 8;
  localparam int unsigned AddrW      = 20;
  localparam int unsigned StatusW    = 2;

  localparam logic [GprIdxW-1:0] SP_INDEX  = GprIdxW'(4);
  localparam logic [WordW-1:0]   SEG_STEP  = 16'h1000;
  localparam logic [WordW-1:0]   SP_RESET  = 16'hFFFF;
  localparam logic [WordW-1:0]   CS_RESET  = 16'hFFFF;
  localparam logic [AddrW:0]     ONE_MIB   = 21'h10_0000;

  // Opcode groups: upper five bits of the opcode, register in the low three
  localparam logic [4:0] OP_GRP_INC  = 5'(8'h40 >> 3);
  localparam logic [4:0] OP_GRP_DEC  = 5'(8'h48 >> 3);
  localparam logic [4:0] OP_GRP_PUSH = 5'(8'h50 >> 3);
  localparam logic [4:0] OP_GRP_POP  = 5'(8'h58 >> 3);
  localparam logic [4:0] OP_GRP_MOV  = 5'(8'hB8 >> 3);

  typedef enum logic [StatusW-1:0] {
    STATUS_OK        = 2'd0,
    STATUS_STACK_VIO = 2'd1,
    STATUS_CUT_OFF   = 2'd2
  } status_e;

  // Linear address: offset + segment*16, wrapping at 1 MiB
  function automatic logic [AddrW-1:0] linear_of(input logic [WordW-1:0] off,
                                                 input logic [WordW-1:0] seg);
    return {4'b0000, off} + {seg, 4'b0000};
  endfunction

endpackage

`default_nettype wire

### rtl/core/srse_in_if.sv
`default_nettype none

interface srse_in_if;
  import srse_pkg::*;

  logic               valid;
  logic               ready;
  logic [ByteW-1:0]   opcode_byte;
  logic [ByteW-1:0]   imm_low;
  logic [ByteW-1:0]   imm_high;
  logic [WordW-1:0]   stack_read_word;

  modport source (
    output valid, opcode_byte, imm_low, imm_high, stack_read_word,
    input  ready
  );

  modport sink (
    input  valid, opcode_byte, imm_low, imm_high, stack_read_word,
    output ready
  );

endinterface

`default_nettype wire

### rtl/core/srse_out_if.sv
`default_nettype none

interface srse_out_if;
  import srse_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [StatusW-1:0]   status;
  logic                 mem_write_en;
  logic [AddrW-1:0]     mem_write_addr;
  logic [WordW-1:0]     mem_write_data;
  logic                 reg_write_en;
  logic [GprIdxW-1:0]   reg_write_index;
  logic [WordW-1:0]     reg_write_value;
  logic [AddrW-1:0]     next_fetch_addr;
  logic [AddrW-1:0]     next_stack_addr;

  modport source (
    output valid, status, mem_write_en, mem_write_addr, mem_write_data,
           reg_write_en, reg_write_index, reg_write_value,
           next_fetch_addr, next_stack_addr,
    input  ready
  );

  modport sink (
    input  valid, status, mem_write_en, mem_write_addr, mem_write_data,
           reg_write_en, reg_write_index, reg_write_value,
           next_fetch_addr, next_stack_addr,
    output ready
  );

endinterface

`default_nettype wire

### rtl/core/segmented_reg_stack_exec_core.sv
`default_nettype none

// Channel | Dir | Word contents
// --------+-----+-----------------------------------------------------------
// in_i    | in  | opcode byte, immediate low/high bytes, stack read word
// out_o   | out | status, memory write, register write, next CS:IP / SS:SP
//
// One instruction per cycle sustained while out_o is not stalled; each word passes
// through the input register, then execute into the result register.
// Architectural state (GPRs, IP, CS, SS) updates as a word leaves the input
// register, so the next word sees it with no bubble.
// in_i.ready drops only when both the input register and the result register
// are full and out_o is stalled.
// Reset: GPRs zero with SP = 0xFFFF, IP = 0, CS = 0xFFFF, SS = 0.

module segmented_reg_stack_exec_core (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  srse_in_if.sink    in_i,
  srse_out_if.source out_o
);
  import srse_pkg::*;

  // Input register
  logic               s1_valid_q;
  logic [ByteW-1:0]   s1_op_q;
  logic [ByteW-1:0]   s1_lo_q;
  logic [ByteW-1:0]   s1_hi_q;
  logic [WordW-1:0]   s1_pop_q;

  // Architectural state
  logic [WordW-1:0]   gpr_q [NumGpr];
  logic [WordW-1:0]   ip_q, cs_q, ss_q;
  logic [WordW-1:0]   ip_d, cs_d, ss_d;

  // Result register
  logic               out_valid_q;
  status_e            status_q, status_d;
  logic               mwe_q, mwe_d;
  logic [AddrW-1:0]   maddr_q, maddr_d;
  logic [WordW-1:0]   mdata_q, mdata_d;
  logic               rwe_q, rwe_d;
  logic [GprIdxW-1:0] ridx_q, ridx_d;
  logic [WordW-1:0]   rval_q, rval_d;
  logic [AddrW-1:0]   nfetch_q, nfetch_d;
  logic [AddrW-1:0]   nstack_q, nstack_d;

  logic advance;
  logic in_fire;

  // Execute-stage working signals
  logic [GprIdxW-1:0] r_idx;
  logic [WordW-1:0]   cur_val;
  logic [WordW-1:0]   sp_cur;
  logic [AddrW-1:0]   fetch_lin;
  logic [AddrW-1:0]   sp_lin;
  logic [WordW-1:0]   pop_base;
  logic [WordW:0]     pop_sum;
  logic [WordW:0]     ip_sum;
  logic [1:0]         ip_step;
  logic               gpr_wr;
  logic [WordW-1:0]   gpr_val;
  logic               sp_wr;
  logic [WordW-1:0]   sp_new;
  logic [WordW-1:0]   sp_final;

  // Handshake: result register drains, input register refills behind it
  assign advance  = !out_valid_q || out_o.ready;
  assign in_i.ready = !s1_valid_q || advance;
  assign in_fire  = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_op_q  <= in_i.opcode_byte;
      s1_lo_q  <= in_i.imm_low;
      s1_hi_q  <= in_i.imm_high;
      s1_pop_q <= in_i.stack_read_word;
    end
  end

  // Decode and execute one instruction
  always_comb begin
    r_idx     = s1_op_q[GprIdxW-1:0];
    cur_val   = gpr_q[r_idx];
    sp_cur    = gpr_q[SP_INDEX];
    fetch_lin = linear_of(ip_q, cs_q);
    sp_lin    = linear_of(sp_cur, ss_q);
    pop_base  = (r_idx == SP_INDEX) ? s1_pop_q : sp_cur;
    pop_sum   = {1'b0, pop_base} + 17'd2;

    status_d = STATUS_OK;
    mwe_d    = 1'b0;
    maddr_d  = '0;
    mdata_d  = '0;
    gpr_wr   = 1'b0;
    gpr_val  = '0;
    sp_wr    = 1'b0;
    sp_new   = sp_cur;
    ss_d     = ss_q;
    ip_step  = 2'd0;

    case (s1_op_q[ByteW-1:GprIdxW])
      OP_GRP_INC: begin
        gpr_wr  = 1'b1;
        gpr_val = cur_val + 16'd1;
        ip_step = 2'd1;
      end
      OP_GRP_DEC: begin
        gpr_wr  = 1'b1;
        gpr_val = cur_val - 16'd1;
        ip_step = 2'd1;
      end
      OP_GRP_PUSH: begin
        if (sp_lin < 20'd2) begin
          status_d = STATUS_STACK_VIO;
        end else begin
          sp_wr = 1'b1;
          // Borrow out of the offset moves the segment down by 0x1000
          if (sp_cur < 16'd2) begin
            sp_new = 16'hFFFD + sp_cur;
            ss_d   = ss_q - SEG_STEP;
          end else begin
            sp_new = sp_cur - 16'd2;
          end
          mwe_d   = 1'b1;
          maddr_d = sp_lin - 20'd2;
          mdata_d = (r_idx == SP_INDEX) ? sp_new : cur_val;
          ip_step = 2'd1;
        end
      end
      OP_GRP_POP: begin
        gpr_wr  = 1'b1;
        gpr_val = s1_pop_q;
        sp_wr   = 1'b1;
        // Carry out of the offset sets it to 1 and bumps the segment
        if (pop_sum[WordW]) begin
          sp_new = 16'd1;
          ss_d   = ss_q + SEG_STEP;
        end else begin
          sp_new = pop_sum[WordW-1:0];
        end
        ip_step = 2'd1;
      end
      OP_GRP_MOV: begin
        if (({1'b0, fetch_lin} + 21'd3) >= ONE_MIB) begin
          status_d = STATUS_CUT_OFF;
        end else begin
          gpr_wr  = 1'b1;
          gpr_val = {s1_hi_q, s1_lo_q};
          ip_step = 2'd3;
        end
      end
      default: begin
      end
    endcase

    // SP update wins over the register write when both name SP
    if (sp_wr) begin
      sp_final = sp_new;
    end else if (gpr_wr && (r_idx == SP_INDEX)) begin
      sp_final = gpr_val;
    end else begin
      sp_final = sp_cur;
    end

    rwe_d  = gpr_wr;
    ridx_d = gpr_wr ? r_idx : '0;
    rval_d = '0;
    if (gpr_wr) begin
      rval_d = (r_idx == SP_INDEX) ? sp_final : gpr_val;
    end

    // IP advance with the same carry rule as SP
    ip_sum = {1'b0, ip_q} + {15'd0, ip_step};
    ip_d   = ip_q;
    cs_d   = cs_q;
    if (status_d == STATUS_OK) begin
      if (ip_sum[WordW]) begin
        ip_d = {14'd0, ip_step} - 16'd1;
        cs_d = cs_q + SEG_STEP;
      end else begin
        ip_d = ip_sum[WordW-1:0];
      end
    end

    nfetch_d = linear_of(ip_d, cs_d);
    nstack_d = linear_of(sp_final, ss_d);
  end

  // Architectural state, committed as a word enters the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumGpr; i++) begin
        gpr_q[i] <= '0;
      end
      gpr_q[SP_INDEX] <= SP_RESET;
      ip_q <= '0;
      cs_q <= CS_RESET;
      ss_q <= '0;
    end else if (s1_valid_q && advance) begin
      // SP itself is always written from sp_final
      if (gpr_wr && (r_idx != SP_INDEX)) begin
        gpr_q[r_idx] <= gpr_val;
      end
      gpr_q[SP_INDEX] <= sp_final;
      ip_q <= ip_d;
      cs_q <= cs_d;
      ss_q <= ss_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q && advance) begin
      status_q <= status_d;
      mwe_q    <= mwe_d;
      maddr_q  <= maddr_d;
      mdata_q  <= mdata_d;
      rwe_q    <= rwe_d;
      ridx_q   <= ridx_d;
      rval_q   <= rval_d;
      nfetch_q <= nfetch_d;
      nstack_q <= nstack_d;
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.status          = status_q;
  assign out_o.mem_write_en    = mwe_q;
  assign out_o.mem_write_addr  = maddr_q;
  assign out_o.mem_write_data  = mdata_q;
  assign out_o.reg_write_en    = rwe_q;
  assign out_o.reg_write_index = ridx_q;
  assign out_o.reg_write_value = rval_q;
  assign out_o.next_fetch_addr = nfetch_q;
  assign out_o.next_stack_addr = nstack_q;

`ifndef SYNTHESIS
  // A pushed word only goes out on a successful step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && mwe_q |-> status_q == STATUS_OK && !rwe_q)
    else $error("memory write alongside fault or register write");

  // Faulted steps leave the fetch address where it was
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && advance && status_d != STATUS_OK |-> ip_d == ip_q && cs_d == cs_q)
    else $error("IP moved on a faulted step");

  // Back-pressure reaches the input only with both stages full and stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> s1_valid_q && out_valid_q && !out_o.ready)
    else $error("input stalled without a full pipeline");

  // Idle register-write fields stay clear
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !rwe_q |-> ridx_q == '0 && rval_q == '0)
    else $error("register write fields set without write enable");

  // A stalled result is neither lost nor overwritten
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_o.ready |=> out_valid_q && $stable(nfetch_q) && $stable(nstack_q))
    else $error("stalled result changed");
`endif

endmodule

`default_nettype wire

### sim/tb_segmented_reg_stack_exec_core.sv
module tb_segmented_reg_stack_exec_core;
  import srse_pkg::*;

  // Register names in 8086 encoding order (SP_INDEX comes from the package)
  localparam logic [GprIdxW-1:0] REG_AX = 3'd0;
  localparam logic [GprIdxW-1:0] REG_CX = 3'd1;
  localparam logic [GprIdxW-1:0] REG_DX = 3'd2;
  localparam logic [GprIdxW-1:0] REG_BX = 3'd3;
  localparam logic [GprIdxW-1:0] REG_BP = 3'd5;
  localparam logic [GprIdxW-1:0] REG_SI = 3'd6;
  localparam logic [GprIdxW-1:0] REG_DI = 3'd7;

  // Opcodes outside every executed group, at both ends of the byte
  localparam logic [ByteW-1:0] OP_UNDEF_LO = 8'h00;
  localparam logic [ByteW-1:0] OP_UNDEF_HI = 8'hFF;

  localparam int RAND_PER_PHASE = 286;
  localparam int STALL_LIMIT    = 2000;
  localparam int DRAIN_CYCLES   = 8;

  typedef struct packed {
    logic [ByteW-1:0] opcode;
    logic [ByteW-1:0] imm_low;
    logic [ByteW-1:0] imm_high;
    logic [WordW-1:0] stack_word;
  } instr_t;

  typedef struct packed {
    status_e              status;
    logic                 mem_write_en;
    logic [AddrW-1:0]     mem_write_addr;
    logic [WordW-1:0]     mem_write_data;
    logic                 reg_write_en;
    logic [GprIdxW-1:0]   reg_write_index;
    logic [WordW-1:0]     reg_write_value;
    logic [AddrW-1:0]     next_fetch_addr;
    logic [AddrW-1:0]     next_stack_addr;
  } effect_t;

  logic clk;
  logic rst_n;

  srse_in_if  instr_if ();
  srse_out_if effect_if ();

  segmented_reg_stack_exec_core dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (instr_if),
    .out_o  (effect_if)
  );

  // Architectural state as the core should hold it
  logic [WordW-1:0] arch_gpr [NumGpr];
  logic [WordW-1:0] arch_ip;
  logic [WordW-1:0] arch_cs;
  logic [WordW-1:0] arch_ss;

  instr_t  instr_q [$];
  effect_t effect_q [$];

  int send_idle_pct;
  int stall_pct;
  int n_issued;
  int n_accepted;
  int n_checked;
  int n_mismatch;
  int n_faults;
  int n_cutoffs;
  int n_ss_moves;
  int idle_cycles;

  // Linear address, wrapping at 1 MiB
  function automatic logic [AddrW-1:0] phys_addr(input logic [WordW-1:0] off,
                                                 input logic [WordW-1:0] seg);
    return AddrW'({4'b0000, off}) + AddrW'({seg, 4'b0000});
  endfunction

  // Upward offset step, returns {segment, offset}; overflow keeps n-1 and
  // bumps the segment
  function automatic logic [2*WordW-1:0] step_offset(input logic [WordW-1:0] off,
                                                     input logic [WordW-1:0] seg,
                                                     input logic [WordW-1:0] n);
    if ({1'b0, off} + {1'b0, n} > 17'h0FFFF)
      return {seg + SEG_STEP, n - 16'd1};
    return {seg, off + n};
  endfunction

  // Executes one instruction on the architectural state, returns its effect
  function automatic effect_t execute_instruction(input instr_t it);
    effect_t              e;
    logic [GprIdxW-1:0]   idx;
    logic [AddrW-1:0]     fetch;
    logic [AddrW-1:0]     sp_lin;
    logic [WordW-1:0]     step;
    logic [WordW-1:0]     ss_was;
    e      = '0;
    e.status = STATUS_OK;
    idx    = it.opcode[2:0];
    step   = '0;
    ss_was = arch_ss;
    fetch  = phys_addr(arch_ip, arch_cs);
    case (it.opcode[7:3])
      OP_GRP_INC: begin
        arch_gpr[idx] = arch_gpr[idx] + 16'd1;
        e.reg_write_en = 1'b1;
        step = 16'd1;
      end
      OP_GRP_DEC: begin
        arch_gpr[idx] = arch_gpr[idx] - 16'd1;
        e.reg_write_en = 1'b1;
        step = 16'd1;
      end
      OP_GRP_PUSH: begin
        sp_lin = phys_addr(arch_gpr[SP_INDEX], arch_ss);
        if (sp_lin < 2) begin
          e.status = STATUS_STACK_VIO;
          n_faults++;
        end else begin
          // borrow keeps 0xFFFF - 2 + offset
          if (arch_gpr[SP_INDEX] < 16'd2) begin
            arch_gpr[SP_INDEX] = 16'hFFFD + arch_gpr[SP_INDEX];
            arch_ss = arch_ss - SEG_STEP;
          end else begin
            arch_gpr[SP_INDEX] = arch_gpr[SP_INDEX] - 16'd2;
          end
          e.mem_write_en   = 1'b1;
          e.mem_write_addr = sp_lin - AddrW'(2);
          e.mem_write_data = arch_gpr[idx];
          step = 16'd1;
        end
      end
      OP_GRP_POP: begin
        arch_gpr[idx] = it.stack_word;
        {arch_ss, arch_gpr[SP_INDEX]} = step_offset(arch_gpr[SP_INDEX], arch_ss, 16'd2);
        e.reg_write_en = 1'b1;
        step = 16'd1;
      end
      OP_GRP_MOV: begin
        if ({1'b0, fetch} + 21'd3 >= ONE_MIB) begin
          e.status = STATUS_CUT_OFF;
          n_cutoffs++;
        end else begin
          arch_gpr[idx] = {it.imm_high, it.imm_low};
          e.reg_write_en = 1'b1;
          step = 16'd3;
        end
      end
      default: ;
    endcase
    if (e.reg_write_en) begin
      e.reg_write_index = idx;
      e.reg_write_value = arch_gpr[idx];
    end
    if (e.status == STATUS_OK)
      {arch_cs, arch_ip} = step_offset(arch_ip, arch_cs, step);
    if (arch_ss != ss_was)
      n_ss_moves++;
    e.next_fetch_addr = phys_addr(arch_ip, arch_cs);
    e.next_stack_addr = phys_addr(arch_gpr[SP_INDEX], arch_ss);
    return e;
  endfunction

  function automatic string effect_str(input effect_t e);
    return $sformatf("st=%0d mem=%b @%h=%h reg=%b r%0d=%h fetch=%h stack=%h",
                     e.status, e.mem_write_en, e.mem_write_addr, e.mem_write_data,
                     e.reg_write_en, e.reg_write_index, e.reg_write_value,
                     e.next_fetch_addr, e.next_stack_addr);
  endfunction

  task automatic queue_instr(input logic [ByteW-1:0] op, input logic [WordW-1:0] imm,
                             input logic [WordW-1:0] word);
    instr_t it;
    it.opcode     = op;
    it.imm_low    = imm[7:0];
    it.imm_high   = imm[15:8];
    it.stack_word = word;
    instr_q.push_back(it);
    n_issued++;
  endtask

  // Stack words leaning towards the ends of the offset range
  function automatic logic [WordW-1:0] pick_stack_word();
    case ($urandom_range(0, 3))
      0:       return 16'($urandom_range(0, 3));
      1:       return 16'hFFFF - 16'($urandom_range(0, 3));
      default: return 16'($urandom);
    endcase
  endfunction

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Driver: feeds queued instructions, predicts each accepted word
  always @(posedge clk) begin : drive_p
    instr_t nxt;
    if (rst_n) begin
      if (instr_if.valid && instr_if.ready) begin
        effect_q.push_back(execute_instruction({instr_if.opcode_byte, instr_if.imm_low,
                                                instr_if.imm_high,
                                                instr_if.stack_read_word}));
        n_accepted <= n_accepted + 1;
      end
      if (!instr_if.valid || instr_if.ready) begin
        if (instr_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          nxt = instr_q.pop_front();
          instr_if.valid           <= 1'b1;
          instr_if.opcode_byte     <= nxt.opcode;
          instr_if.imm_low         <= nxt.imm_low;
          instr_if.imm_high        <= nxt.imm_high;
          instr_if.stack_read_word <= nxt.stack_word;
        end else begin
          instr_if.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: random back-pressure, checks each result word against the oldest prediction
  always @(posedge clk) begin : check_p
    effect_t want;
    effect_t got;
    if (rst_n) begin
      effect_if.ready <= ($urandom_range(0, 99) >= stall_pct);
      if (effect_if.valid && effect_if.ready) begin
        got.status          = status_e'(effect_if.status);
        got.mem_write_en    = effect_if.mem_write_en;
        got.mem_write_addr  = effect_if.mem_write_addr;
        got.mem_write_data  = effect_if.mem_write_data;
        got.reg_write_en    = effect_if.reg_write_en;
        got.reg_write_index = effect_if.reg_write_index;
        got.reg_write_value = effect_if.reg_write_value;
        got.next_fetch_addr = effect_if.next_fetch_addr;
        got.next_stack_addr = effect_if.next_stack_addr;
        n_checked++;
        if (effect_q.size() == 0) begin
          n_mismatch++;
          if (n_mismatch <= 10)
            $display("unexpected result word: %s", effect_str(got));
        end else begin
          want = effect_q.pop_front();
          if (got !== want) begin
            n_mismatch++;
            if (n_mismatch <= 10) begin
              $display("mismatch on result %0d", n_checked);
              $display("  expected %s", effect_str(want));
              $display("  actual   %s", effect_str(got));
            end
          end
        end
      end
    end
  end

  // Watchdog on cycles with no word moving on either side
  always @(posedge clk) begin
    if ((instr_if.valid && instr_if.ready) || (effect_if.valid && effect_if.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles == STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Stimulus and run control
  initial begin : stimulus
    int               p;
    int               kind;
    int               known;
    int               burst;
    logic [ByteW-1:0] op;
    rst_n                    = 1'b0;
    instr_if.valid           = 1'b0;
    instr_if.opcode_byte     = '0;
    instr_if.imm_low         = '0;
    instr_if.imm_high        = '0;
    instr_if.stack_read_word = '0;
    effect_if.ready          = 1'b0;
    send_idle_pct = 0;
    stall_pct     = 0;
    n_issued      = 0;
    n_accepted    = 0;
    n_checked     = 0;
    n_mismatch    = 0;
    n_faults      = 0;
    n_cutoffs     = 0;
    n_ss_moves    = 0;
    idle_cycles   = 0;
    for (int i = 0; i < NumGpr; i++)
      arch_gpr[i] = '0;
    arch_gpr[SP_INDEX] = SP_RESET;
    arch_ip = '0;
    arch_cs = CS_RESET;
    arch_ss = '0;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: fetch starts at 0xFFFF0, so MOVs at IP 13..15 are cut off;
    // then the stack is driven through a segment carry, a borrow and both
    // faulting addresses
    queue_instr({OP_GRP_MOV, REG_AX}, 16'h0000, 16'h0000);
    queue_instr({OP_GRP_MOV, REG_DI}, 16'hFFFF, 16'hFFFF);
    queue_instr({OP_GRP_DEC, REG_CX}, 16'h0000, 16'h0000);
    queue_instr({OP_GRP_INC, REG_DI}, 16'hFFFF, 16'hFFFF);
    queue_instr({OP_GRP_PUSH, REG_DI}, 16'h0000, 16'h0000);
    queue_instr({OP_GRP_PUSH, SP_INDEX}, 16'h0000, 16'h0000);
    queue_instr(OP_UNDEF_LO, 16'h0000, 16'h0000);
    queue_instr(OP_UNDEF_HI, 16'hFFFF, 16'hFFFF);
    queue_instr({OP_GRP_INC, REG_BP}, 16'h0000, 16'h0000);
    queue_instr({OP_GRP_POP, REG_BX}, 16'h0000, 16'h8001);
    queue_instr({OP_GRP_INC, REG_SI}, 16'h0000, 16'h0000);
    queue_instr({OP_GRP_MOV, REG_DX}, 16'h1234, 16'h0000);
    queue_instr({OP_GRP_INC, REG_AX}, 16'h0000, 16'h0000);
    queue_instr({OP_GRP_MOV, REG_BX}, 16'h5AA5, 16'h0000);
    queue_instr({OP_GRP_DEC, SP_INDEX}, 16'h0000, 16'h0000);
    queue_instr({OP_GRP_MOV, REG_CX}, 16'h00FF, 16'h0000);
    queue_instr({OP_GRP_INC, SP_INDEX}, 16'h0000, 16'h0000);
    queue_instr({OP_GRP_POP, SP_INDEX}, 16'h0000, 16'hFFFE);
    queue_instr({OP_GRP_PUSH, REG_AX}, 16'h0000, 16'h0000);
    queue_instr({OP_GRP_POP, SP_INDEX}, 16'h0000, 16'h0001);
    queue_instr({OP_GRP_PUSH, REG_BX}, 16'h0000, 16'h0000);
    queue_instr({OP_GRP_PUSH, REG_CX}, 16'h0000, 16'h0000);
    queue_instr({OP_GRP_POP, SP_INDEX}, 16'h0000, 16'h0000);
    queue_instr({OP_GRP_PUSH, REG_DI}, 16'h0000, 16'h0000);
    queue_instr({OP_GRP_PUSH, REG_AX}, 16'h0000, 16'h0000);

    // Random phases: free running, sparse sender, stalling sink, both
    for (p = 0; p < 4; p++) begin
      case (p)
        0:       begin send_idle_pct = 0;  stall_pct = 0;  end
        1:       begin send_idle_pct = 63; stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  stall_pct = 63; end
        default: begin send_idle_pct = 31; stall_pct = 31; end
      endcase
      known = 0;
      while (known < RAND_PER_PHASE) begin
        kind = $urandom_range(0, 99);
        if (kind < 12) begin
          queue_instr({(kind < 6) ? OP_GRP_INC : OP_GRP_DEC, 3'($urandom_range(0, 7))},
                      16'($urandom), pick_stack_word());
          known++;
        end else if (kind < 34) begin
          queue_instr({OP_GRP_PUSH, 3'($urandom_range(0, 7))}, 16'($urandom),
                      16'($urandom));
          known++;
        end else if (kind < 54) begin
          queue_instr({OP_GRP_POP, 3'($urandom_range(0, 7))}, 16'($urandom),
                      pick_stack_word());
          known++;
        end else if (kind < 70) begin
          queue_instr({OP_GRP_MOV, 3'($urandom_range(0, 7))}, 16'($urandom),
                      16'($urandom));
          known++;
        end else if (kind < 80) begin
          // noise: any byte outside the executed groups
          op = 8'($urandom_range(0, 255));
          while (op[7:3] == OP_GRP_INC || op[7:3] == OP_GRP_DEC || op[7:3] == OP_GRP_PUSH ||
                 op[7:3] == OP_GRP_POP || op[7:3] == OP_GRP_MOV)
            op = 8'($urandom_range(0, 255));
          queue_instr(op, 16'($urandom), 16'($urandom));
        end else if (kind < 90) begin
          // stack pulled to the bottom, then pushes into the fault zone
          burst = $urandom_range(1, 4);
          queue_instr({OP_GRP_POP, SP_INDEX}, 16'($urandom), 16'($urandom_range(0, 5)));
          repeat (burst)
            queue_instr({OP_GRP_PUSH, 3'($urandom_range(0, 7))}, 16'($urandom),
                        16'($urandom));
          known += burst + 1;
        end else begin
          // stack at the top of its offset: carries and borrows of SS
          burst = $urandom_range(1, 4);
          queue_instr({OP_GRP_POP, SP_INDEX}, 16'($urandom),
                      16'($urandom_range(16'hFFF8, 16'hFFFF)));
          repeat (burst)
            queue_instr({($urandom_range(0, 1) != 0) ? OP_GRP_PUSH : OP_GRP_POP,
                         3'($urandom_range(0, 7))}, 16'($urandom), pick_stack_word());
          known += burst + 1;
        end
      end
      while (n_accepted < n_issued)
        @(posedge clk);
    end

    // Drain, then watch a little longer for stray words
    while (effect_q.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Checked %0d result words for %0d instructions over four pacing phases.",
             n_checked, n_issued);
    $display("Stack faults %0d, cut-off MOVs %0d, SS carries/borrows %0d, mismatches %0d.",
             n_faults, n_cutoffs, n_ss_moves, n_mismatch);
    if (n_mismatch == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
